// File: rtl/aaq_pkg.sv
`timescale 1ns / 1ps
package aaq_pkg;

	typedef struct packed {
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic signed [15:0] angle;
	} aaq_in_t;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic               zero_axis;
	} aaq_out_t;

	localparam int CORDIC_STEPS = 16;
	localparam int ISQRT_BITS   = 24;
	localparam int DIV_BITS     = 15;

	localparam logic signed [31:0] GAIN_S    = 32'sd163008218;
	localparam logic signed [31:0] PI_S      = 32'sd843314857;
	localparam logic signed [31:0] HALF_PI_S = 32'sd421657428;
	localparam logic signed [31:0] ANG_ONE   = 32'sd268435456;

	localparam logic signed [31:0] ATAN_HEAD [10] = '{
		32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
		32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287
	};

	// stage numbers, input register is stage 1
	localparam int LAT_LEN    = 3 + ISQRT_BITS;
	localparam int LAT_Q      = LAT_LEN + DIV_BITS;
	localparam int LAT_LANE   = LAT_Q + 2;
	localparam int LAT_TRIG   = CORDIC_STEPS + 3;
	localparam int PIPE_DEPTH = LAT_LANE + 1;
	localparam int DLY_AXIS   = LAT_LEN - 1;
	localparam int DLY_SIN    = LAT_Q - LAT_TRIG;
	localparam int DLY_COS    = LAT_LANE - LAT_TRIG;
	localparam int DLY_ZERO   = LAT_LANE - 3;

	function automatic logic signed [31:0] atan_ent(input int unsigned i);
		logic signed [31:0] r;
		if (i < 10) begin
			r = ATAN_HEAD[i[3:0]];
		end else begin
			r = ANG_ONE >>> i;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
		logic signed [32:0] s;
		logic signed [18:0] r;
		logic signed [15:0] o;
		s = {v[31], v} + 33'sd8192;
		r = 19'(s >>> 14);
		if (r > 19'sd16384) begin
			o = 16'sd16384;
		end else if (r < -19'sd16384) begin
			o = -16'sd16384;
		end else begin
			o = r[15:0];
		end
		return o;
	endfunction

endpackage

// File: rtl/aaq_norm.sv
`timescale 1ns / 1ps
module aaq_norm (
	input  logic                clk,
	input  logic                en,
	input  logic signed [15:0]  axis_x,
	input  logic signed [15:0]  axis_y,
	input  logic signed [15:0]  axis_z,
	output logic                zero,
	output logic [aaq_pkg::ISQRT_BITS-1:0] len
);
	localparam int NB = aaq_pkg::ISQRT_BITS;
	localparam int RW = 2 * NB + 2;

	logic signed [31:0] sqx_s2, sqy_s2, sqz_s2;
	logic [31:0]        sum_s3;
	logic               zero_s3;
	logic [RW-1:0]      rem0;
	logic [RW-1:0]      rem_s  [NB];
	logic [NB-1:0]      root_s [NB];

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= axis_x * axis_x;
			sqy_s2 <= axis_y * axis_y;
			sqz_s2 <= axis_z * axis_z;
			sum_s3 <= 32'(sqx_s2) + 32'(sqy_s2) + 32'(sqz_s2);
			zero_s3 <= (sqx_s2 == 32'sd0) && (sqy_s2 == 32'sd0) && (sqz_s2 == 32'sd0);
		end
	end

	assign rem0 = {(RW - 48)'(0), sum_s3, 16'b0};

	// one root bit per stage, most significant first
	for (genvar j = 0; j < NB; j++) begin : g_step
		localparam int K = NB - 1 - j;
		logic [RW-1:0] rem_in, trial;
		logic [NB-1:0] root_in;
		if (j == 0) begin : g_first
			assign rem_in  = rem0;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
		end
		assign trial = ({(RW - NB)'(0), root_in} << (K + 1)) + (RW'(1) << (2 * K));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[j]  <= rem_in - trial;
					root_s[j] <= root_in | (NB'(1) << K);
				end else begin
					rem_s[j]  <= rem_in;
					root_s[j] <= root_in;
				end
			end
		end
	end

	assign zero = zero_s3;
	assign len  = root_s[NB-1];
endmodule

// File: rtl/aaq_cordic.sv
`timescale 1ns / 1ps
module aaq_cordic (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] angle,
	output logic signed [15:0] cos_v,
	output logic signed [15:0] sin_v
);
	localparam int NS = aaq_pkg::CORDIC_STEPS;

	logic signed [31:0] half;
	logic signed [31:0] x_s [NS+1];
	logic signed [31:0] y_s [NS+1];
	logic signed [31:0] z_s [NS+1];
	logic               f_s [NS+1];
	logic signed [15:0] cos_s, sin_s;

	assign half = {angle[15], angle, 15'b0};

	// fold the half angle into the CORDIC range, negate both results later
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= aaq_pkg::GAIN_S;
			y_s[0] <= '0;
			if (half > aaq_pkg::HALF_PI_S) begin
				z_s[0] <= half - aaq_pkg::PI_S;
				f_s[0] <= 1'b1;
			end else if (half < -aaq_pkg::HALF_PI_S) begin
				z_s[0] <= half + aaq_pkg::PI_S;
				f_s[0] <= 1'b1;
			end else begin
				z_s[0] <= half;
				f_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_step
		logic signed [31:0] dx, dy, at;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = aaq_pkg::atan_ent(i);
		always_ff @(posedge clk) begin
			if (en) begin
				f_s[i+1] <= f_s[i];
				if (!z_s[i][31]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s <= aaq_pkg::to_q14(f_s[NS] ? -x_s[NS] : x_s[NS]);
			sin_s <= aaq_pkg::to_q14(f_s[NS] ? -y_s[NS] : y_s[NS]);
		end
	end

	assign cos_v = cos_s;
	assign sin_v = sin_s;
endmodule

// File: rtl/aaq_lane.sv
`timescale 1ns / 1ps
module aaq_lane (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [15:0]              comp,
	input  logic [aaq_pkg::ISQRT_BITS-1:0]  len,
	input  logic signed [15:0]              sin_v,
	output logic signed [15:0]              q14
);
	localparam int NB = aaq_pkg::ISQRT_BITS;
	localparam int QB = aaq_pkg::DIV_BITS;
	localparam int RW = 40;

	logic [15:0]        mag;
	logic [RW-1:0]      num;
	logic [RW-1:0]      rem_s [QB];
	logic [QB-1:0]      q_s   [QB];
	logic [NB-1:0]      len_s [QB];
	logic               neg_s [QB];
	logic signed [15:0] n;
	logic signed [31:0] prod_s;
	logic signed [15:0] res_s;

	assign mag = comp[15] ? 16'(-comp) : 16'(comp);
	assign num = {(RW - 38)'(0), mag, 22'b0} + {(RW - NB)'(0), len >> 1};

	// restoring divide, one quotient bit per stage
	for (genvar j = 0; j < QB; j++) begin : g_step
		localparam int K = QB - 1 - j;
		logic [RW-1:0] rem_in, dv;
		logic [QB-1:0] q_in;
		logic [NB-1:0] len_in;
		logic          neg_in;
		if (j == 0) begin : g_first
			assign rem_in = num;
			assign q_in   = '0;
			assign len_in = len;
			assign neg_in = comp[15];
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign q_in   = q_s[j-1];
			assign len_in = len_s[j-1];
			assign neg_in = neg_s[j-1];
		end
		assign dv = {(RW - NB)'(0), len_in} << K;
		always_ff @(posedge clk) begin
			if (en) begin
				len_s[j] <= len_in;
				neg_s[j] <= neg_in;
				if (rem_in >= dv) begin
					rem_s[j] <= rem_in - dv;
					q_s[j]   <= q_in | (QB'(1) << K);
				end else begin
					rem_s[j] <= rem_in;
					q_s[j]   <= q_in;
				end
			end
		end
	end

	assign n = neg_s[QB-1] ? -$signed({1'b0, q_s[QB-1]}) : $signed({1'b0, q_s[QB-1]});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s <= n * sin_v;
			res_s  <= aaq_pkg::to_q14(prod_s);
		end
	end

	assign q14 = res_s;
endmodule

// File: rtl/axis_angle_to_quaternion_core.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle; the whole pipeline holds while an output
// beat waits for out_ready, and the 24-stage root plus 15-stage divide set the depth.
// Reset clears all stage valid flags; data registers are not reset.
module axis_angle_to_quaternion_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  aaq_pkg::aaq_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output aaq_pkg::aaq_out_t out_data
);
	localparam int PD = aaq_pkg::PIPE_DEPTH;

	logic                     en;
	logic [PD-1:0]            vld_q;
	aaq_pkg::aaq_in_t         in_s1;
	aaq_pkg::aaq_in_t         axis_dly_q [aaq_pkg::DLY_AXIS];
	logic signed [15:0]       sin_dly_q  [aaq_pkg::DLY_SIN];
	logic signed [15:0]       cos_dly_q  [aaq_pkg::DLY_COS];
	logic                     zero_dly_q [aaq_pkg::DLY_ZERO];
	logic                     zero_v;
	logic [aaq_pkg::ISQRT_BITS-1:0] len;
	logic signed [15:0]       cos_v, sin_v;
	logic signed [15:0]       lx, ly, lz;
	aaq_pkg::aaq_out_t        out_q;

	assign en       = !vld_q[PD-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PD-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= in_data;
			axis_dly_q[0] <= in_s1;
			sin_dly_q[0]  <= sin_v;
			cos_dly_q[0]  <= cos_v;
			zero_dly_q[0] <= zero_v;
			for (int i = 1; i < aaq_pkg::DLY_AXIS; i++) axis_dly_q[i] <= axis_dly_q[i-1];
			for (int i = 1; i < aaq_pkg::DLY_SIN; i++)  sin_dly_q[i]  <= sin_dly_q[i-1];
			for (int i = 1; i < aaq_pkg::DLY_COS; i++)  cos_dly_q[i]  <= cos_dly_q[i-1];
			for (int i = 1; i < aaq_pkg::DLY_ZERO; i++) zero_dly_q[i] <= zero_dly_q[i-1];
		end
	end

	aaq_norm u_norm (
		.clk    (clk),
		.en     (en),
		.axis_x (in_s1.axis_x),
		.axis_y (in_s1.axis_y),
		.axis_z (in_s1.axis_z),
		.zero   (zero_v),
		.len    (len)
	);

	aaq_cordic u_cordic (
		.clk   (clk),
		.en    (en),
		.angle (in_s1.angle),
		.cos_v (cos_v),
		.sin_v (sin_v)
	);

	aaq_lane u_lane_x (
		.clk   (clk),
		.en    (en),
		.comp  (axis_dly_q[aaq_pkg::DLY_AXIS-1].axis_x),
		.len   (len),
		.sin_v (sin_dly_q[aaq_pkg::DLY_SIN-1]),
		.q14   (lx)
	);

	aaq_lane u_lane_y (
		.clk   (clk),
		.en    (en),
		.comp  (axis_dly_q[aaq_pkg::DLY_AXIS-1].axis_y),
		.len   (len),
		.sin_v (sin_dly_q[aaq_pkg::DLY_SIN-1]),
		.q14   (ly)
	);

	aaq_lane u_lane_z (
		.clk   (clk),
		.en    (en),
		.comp  (axis_dly_q[aaq_pkg::DLY_AXIS-1].axis_z),
		.len   (len),
		.sin_v (sin_dly_q[aaq_pkg::DLY_SIN-1]),
		.q14   (lz)
	);

	// merge lanes; drop the vector part for a zero-length axis
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.quat_w    <= cos_dly_q[aaq_pkg::DLY_COS-1];
			out_q.zero_axis <= zero_dly_q[aaq_pkg::DLY_ZERO-1];
			out_q.quat_x    <= zero_dly_q[aaq_pkg::DLY_ZERO-1] ? 16'sd0 : lx;
			out_q.quat_y    <= zero_dly_q[aaq_pkg::DLY_ZERO-1] ? 16'sd0 : ly;
			out_q.quat_z    <= zero_dly_q[aaq_pkg::DLY_ZERO-1] ? 16'sd0 : lz;
		end
	end

	assign out_valid = vld_q[PD-1];
	assign out_data  = out_q;

	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_axis |->
			out_data.quat_x == 16'sd0 && out_data.quat_y == 16'sd0 && out_data.quat_z == 16'sd0)
		else $error("zero axis with nonzero vector part");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.quat_w <= 16'sd16384 && out_data.quat_w >= -16'sd16384)
		else $error("quat_w out of range");
endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam int PIPE_LAT = 45;
	localparam int N_RANDOM = 1600;

	typedef struct {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [15:0] ang;
		logic               known;
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               zflag;
	} vec_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	aaq_pkg::aaq_in_t  in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	aaq_pkg::aaq_out_t out_data;

	aaq_pkg::aaq_out_t quat_queue[$];
	logic              known_queue[$];
	aaq_pkg::aaq_out_t known_vals[$];
	int       mismatches = 0;
	bit       calm = 1'b0;
	bit       hold_long = 1'b0;
	bit       stim_done = 1'b0;

	axis_angle_to_quaternion_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20000000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic longint sra(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint fix14(longint v);
		longint r;
		r = sra(v + 64'sd8192, 14);
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return r;
	endfunction

	function automatic longint arctan_step(int i);
		longint head[10];
		head = '{210828714, 124459457, 65760959, 33381290, 16755422,
			8385879, 4193963, 2097109, 1048571, 524287};
		if (i < 10) return head[i];
		return longint'(268435456) >>> i;
	endfunction

	function automatic longint root64(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint unit_part(longint a, longint len);
		longint mag, q;
		mag = a < 0 ? -a : a;
		q = ((mag << 22) + (len >> 1)) / len;
		return a < 0 ? -q : q;
	endfunction

	function automatic aaq_pkg::aaq_out_t rotor_of(aaq_pkg::aaq_in_t d);
		aaq_pkg::aaq_out_t o;
		longint ax, ay, az, half, cx, cy, t, dx, dy, cw, sn, s, len;
		bit flip;
		int steps;
		ax = d.axis_x;
		ay = d.axis_y;
		az = d.axis_z;
		half = longint'(d.angle) * 32768;
		flip = 1'b0;
		cx = 163008218;
		cy = 0;
		steps = aaq_pkg::CORDIC_STEPS > 31 ? 31 : aaq_pkg::CORDIC_STEPS;
		if (half > 421657428) begin
			half -= 843314857;
			flip = 1'b1;
		end else if (half < -421657428) begin
			half += 843314857;
			flip = 1'b1;
		end
		for (int i = 0; i < steps; i++) begin
			dx = sra(cy, i);
			dy = sra(cx, i);
			if (half >= 0) begin
				t = cx - dx;
				cy = cy + dy;
				half -= arctan_step(i);
			end else begin
				t = cx + dx;
				cy = cy - dy;
				half += arctan_step(i);
			end
			cx = t;
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		cw = fix14(cx);
		sn = fix14(cy);
		s = ax * ax + ay * ay + az * az;
		o = '0;
		o.quat_w = 16'(cw);
		o.zero_axis = (s == 0);
		if (s != 0) begin
			len = root64(longint'(s) << 16);
			o.quat_x = 16'(fix14(unit_part(ax, len) * sn));
			o.quat_y = 16'(fix14(unit_part(ay, len) * sn));
			o.quat_z = 16'(fix14(unit_part(az, len) * sn));
		end
		return o;
	endfunction

	task automatic send_beat(aaq_pkg::aaq_in_t d, logic known, aaq_pkg::aaq_out_t kv);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		quat_queue.push_back(rotor_of(d));
		known_queue.push_back(known);
		known_vals.push_back(kv);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// directed rows: two rows at angle zero, one with a zero axis, have results known by hand
	vec_row_t rows[$];
	function automatic vec_row_t mk(int ax, int ay, int az, int an, bit kn,
		int w, int x, int y, int z, bit zf);
		vec_row_t r;
		r.ax = 16'(ax); r.ay = 16'(ay); r.az = 16'(az); r.ang = 16'(an);
		r.known = kn; r.w = 16'(w); r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
		r.zflag = zf;
		return r;
	endfunction

	initial begin
		aaq_pkg::aaq_in_t  d;
		aaq_pkg::aaq_out_t kv;
		vec_row_t r;
		rows.push_back(mk(0, 0, 0, 0, 1, 16384, 0, 0, 0, 1));
		rows.push_back(mk(256, 0, 0, 0, 1, 16384, 0, 0, 0, 0));
		rows.push_back(mk(0, 0, 0, 32767, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(0, 0, 0, -32768, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(32767, 32767, 32767, 6434, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(-32768, -32768, -32768, -6434, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(-32768, 0, 0, 12868, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(0, 1, 0, 6433, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(0, 0, -1, 6435, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(1, -1, 1, -6435, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(32767, -32768, 1, 20000, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(0, 256, 0, -20000, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(100, 200, -300, 1, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(0, 0, 0, 12868, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(-1, -1, -1, -1, 0, 0, 0, 0, 0, 0));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			r = rows[i];
			d = '{axis_x: r.ax, axis_y: r.ay, axis_z: r.az, angle: r.ang};
			kv = '{quat_w: r.w, quat_x: r.x, quat_y: r.y, quat_z: r.z,
				zero_axis: r.zflag};
			send_beat(d, r.known, kv);
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 300) hold_long = 1'b1;
			if (n == N_RANDOM - 200) calm = 1'b1;
			d.axis_x = 16'($urandom);
			d.axis_y = 16'($urandom);
			d.axis_z = 16'($urandom);
			d.angle = 16'($urandom);
			case ($urandom_range(0, 5))
				0: d.axis_x = 16'($signed($urandom_range(0, 8)) - 4);
				1: begin
					d.axis_y = '0;
					d.axis_z = '0;
				end
				2: d.angle = 16'($urandom_range(6400, 6470));
				3: d.angle = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
				default: ;
			endcase
			if ($urandom_range(0, 40) == 0) begin
				d.axis_x = '0; d.axis_y = '0; d.axis_z = '0;
			end
			send_beat(d, 1'b0, '0);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver: random stalls, one long hold-off while the sender keeps pushing
	initial begin
		int gap;
		out_ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				hold_long = 1'b0;
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
			end
			if (!calm && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 11);
				out_ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		aaq_pkg::aaq_out_t e, kv;
		logic kn;
		if (arst_n && out_valid && out_ready) begin
			if (quat_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %p", out_data);
			end else begin
				e = quat_queue.pop_front();
				kn = known_queue.pop_front();
				kv = known_vals.pop_front();
				if (kn && kv != e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("model row disagrees: table %p model %p", kv, e);
				end
				if (out_data.quat_w !== e.quat_w || out_data.quat_x !== e.quat_x ||
					out_data.quat_y !== e.quat_y || out_data.quat_z !== e.quat_z ||
					out_data.zero_axis !== e.zero_axis) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", e, out_data);
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		while (quat_queue.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 20) @(posedge clk);
		if (mismatches == 0 && quat_queue.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
